// ----- rtl/rkwc_pkg.sv -----
// Shared constants, event codes and control types for the key whitelist controller.
package rkwc_pkg;

    localparam int DEF_TABLE_DEPTH = 16;
    localparam int DEF_ID_BYTES    = 4;

    localparam int UID_W     = 32;
    localparam int EV_W      = 3;
    localparam int CNT_OUT_W = 5;
    localparam int RES_W     = EV_W + CNT_OUT_W + 1;
    localparam int RES_PAD_W = ((RES_W + 7) / 8) * 8;

    localparam logic [EV_W-1:0] EV_MASTER_SET = 3'd0;
    localparam logic [EV_W-1:0] EV_GRANTED    = 3'd1;
    localparam logic [EV_W-1:0] EV_DENIED     = 3'd2;
    localparam logic [EV_W-1:0] EV_ENTER      = 3'd3;
    localparam logic [EV_W-1:0] EV_ADDED      = 3'd4;
    localparam logic [EV_W-1:0] EV_REMOVED    = 3'd5;
    localparam logic [EV_W-1:0] EV_LEAVE      = 3'd6;
    localparam logic [EV_W-1:0] EV_FULL       = 3'd7;

    typedef struct packed {
        logic load;
        logic scan;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_last;
    } t_dp_sts;

endpackage

// ----- rtl/rfid_key_whitelist_controller.sv -----
// Top level of the card key whitelist controller.
//
// Each card beat on the slave side gives one result beat on the master side. The first card
// after reset becomes the master key; the master key toggles master mode; other cards are
// checked against the whitelist in normal mode, and removed or added in master mode (event 7
// when no entry is free). Every card passes through the same steps: the beat is taken, each
// table entry is read in turn for the scan through the single read port of the key memory,
// the last entry read is compared, and the result is committed. A new card is accepted while
// the previous result beat waits; the commit of the next card holds until that beat is taken.
// Reset clears the entry valid flags at once, with no clearing pass.
module rfid_key_whitelist_controller
    import rkwc_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int ID_BYTES    = DEF_ID_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [UID_W-1:0]     i_s_tdata,  // card_uid[31:0]
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    output logic [RES_PAD_W-1:0] o_m_tdata   // event_res[2:0], stored_count[7:3], admin_mode[8]
);

    t_dp_cmd              cmd;
    t_dp_sts              sts;
    logic [EV_W-1:0]      event_res;
    logic [CNT_OUT_W-1:0] stored_count;
    logic                 admin_mode;

    rkwc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    rkwc_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ID_BYTES    (ID_BYTES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_card_uid     (i_s_tdata),
        .o_event_res    (event_res),
        .o_stored_count (stored_count),
        .o_admin_mode   (admin_mode)
    );

    assign o_m_tdata = {(RES_PAD_W - RES_W)'(0), admin_mode, stored_count, event_res};

endmodule

// ----- rtl/rkwc_ctrl.sv -----
// Sequencer for key lookup: accept, table scan, drain, commit, and result beat hold.
module rkwc_ctrl
    import rkwc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_tvalid,
    output logic    o_s_tready,
    output logic    o_m_tvalid,
    input  logic    i_m_tready,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_vld;
    logic       n_out_vld;

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.scan   = 1'b0;
        o_cmd.commit = 1'b0;
        o_s_tready   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (!r_out_vld || i_m_tready) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_vld = r_out_vld;
        if (o_cmd.commit) begin
            n_out_vld = 1'b1;
        end else if (r_out_vld && i_m_tready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_m_tvalid = r_out_vld;

endmodule

// ----- rtl/rkwc_dp.sv -----
// Key table, master key, scan pipeline, decision logic and result register.
module rkwc_dp
    import rkwc_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int ID_BYTES    = DEF_ID_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_sts              o_sts,
    input  logic [UID_W-1:0]     i_card_uid,
    output logic [EV_W-1:0]      o_event_res,
    output logic [CNT_OUT_W-1:0] o_stored_count,
    output logic                 o_admin_mode
);

    localparam int KEY_W = (ID_BYTES * 8 > UID_W) ? UID_W : ID_BYTES * 8;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    logic [KEY_W-1:0]       r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid;
    logic [KEY_W-1:0]       r_key;
    logic [KEY_W-1:0]       r_master_key;
    logic                   r_master_vld;
    logic                   r_admin;
    logic [CNT_W-1:0]       r_count;
    logic [IDX_W-1:0]       r_idx;
    logic [KEY_W-1:0]       r_rd_key;
    logic                   r_rd_vld;
    logic [IDX_W-1:0]       r_chk_idx;
    logic                   r_chk_vld;
    logic                   r_found;
    logic [IDX_W-1:0]       r_found_idx;
    logic                   r_free_ok;
    logic [IDX_W-1:0]       r_free_idx;
    logic [EV_W-1:0]        r_ev;
    logic [CNT_OUT_W-1:0]   r_res_count;
    logic                   r_res_admin;

    logic [EV_W-1:0]        n_ev;
    logic [CNT_W-1:0]       n_count;
    logic                   n_admin;
    logic                   n_master_vld;
    logic                   wr_en;
    logic                   clr_en;
    logic                   key_is_master;
    logic [CNT_W+CNT_OUT_W-1:0] cnt_ext;

    assign key_is_master   = (r_key == r_master_key);
    assign o_sts.scan_last = (r_idx == LAST_IDX);

    always_comb begin
        n_ev         = EV_MASTER_SET;
        n_count      = r_count;
        n_admin      = r_admin;
        n_master_vld = r_master_vld;
        wr_en        = 1'b0;
        clr_en       = 1'b0;
        if (!r_master_vld) begin
            n_master_vld = 1'b1;
            n_ev         = EV_MASTER_SET;
        end else if (!r_admin) begin
            if (key_is_master) begin
                n_admin = 1'b1;
                n_ev    = EV_ENTER;
            end else begin
                n_ev = r_found ? EV_GRANTED : EV_DENIED;
            end
        end else if (key_is_master) begin
            n_admin = 1'b0;
            n_ev    = EV_LEAVE;
        end else if (r_found) begin
            clr_en = 1'b1;
            if (r_count != '0) begin
                n_count = r_count - CNT_W'(1);
            end
            n_ev = EV_REMOVED;
        end else if (r_free_ok) begin
            wr_en   = 1'b1;
            n_count = r_count + CNT_W'(1);
            n_ev    = EV_ADDED;
        end else begin
            n_ev = EV_FULL;
        end
    end

    assign cnt_ext = (CNT_W + CNT_OUT_W)'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_master_vld <= 1'b0;
            r_admin      <= 1'b0;
            r_count      <= '0;
            r_idx        <= '0;
            r_chk_vld    <= 1'b0;
            r_found      <= 1'b0;
            r_free_ok    <= 1'b0;
        end else begin
            r_chk_vld <= i_cmd.scan;
            if (i_cmd.load) begin
                r_idx     <= '0;
                r_found   <= 1'b0;
                r_free_ok <= 1'b0;
            end else if (i_cmd.scan && (r_idx != LAST_IDX)) begin
                r_idx <= r_idx + IDX_W'(1);
            end
            if (r_chk_vld) begin
                if (r_rd_vld && (r_rd_key == r_key) && !r_found) begin
                    r_found <= 1'b1;
                end
                if (!r_rd_vld && !r_free_ok) begin
                    r_free_ok <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_master_vld <= n_master_vld;
                r_admin      <= n_admin;
                r_count      <= n_count;
                if (clr_en) begin
                    r_valid[r_found_idx] <= 1'b0;
                end
                if (wr_en) begin
                    r_valid[r_free_idx] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_key  <= r_mem[r_idx];
        r_rd_vld  <= r_valid[r_idx];
        r_chk_idx <= r_idx;
        if (i_cmd.load) begin
            r_key <= i_card_uid[KEY_W-1:0];
        end
        if (r_chk_vld && r_rd_vld && (r_rd_key == r_key) && !r_found) begin
            r_found_idx <= r_chk_idx;
        end
        if (r_chk_vld && !r_rd_vld && !r_free_ok) begin
            r_free_idx <= r_chk_idx;
        end
        if (i_cmd.commit) begin
            if (!r_master_vld) begin
                r_master_key <= r_key;
            end
            if (wr_en) begin
                r_mem[r_free_idx] <= r_key;
            end
            r_ev        <= n_ev;
            r_res_count <= cnt_ext[CNT_OUT_W-1:0];
            r_res_admin <= n_admin;
        end
    end

    assign o_event_res    = r_ev;
    assign o_stored_count = r_res_count;
    assign o_admin_mode   = r_res_admin;

endmodule

// ----- verif/rkwc_checker.sv -----
// Scoreboard for the key whitelist controller: predicts every result beat and compares it.
module rkwc_checker
    import rkwc_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int ID_BYTES    = DEF_ID_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [UID_W-1:0]     i_s_tdata,  // card_uid[31:0]
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [RES_PAD_W-1:0] i_m_tdata,  // event_res[2:0], stored_count[7:3], admin_mode[8]
    output int                   o_pending,
    output int                   o_errors
);

    localparam logic [UID_W-1:0] UID_MASK =
        {UID_W{1'b1}} >> ((ID_BYTES >= 4) ? 0 : UID_W - 8 * ID_BYTES);

    typedef struct packed {
        logic [EV_W-1:0]      ev;
        logic [CNT_OUT_W-1:0] count;
        logic                 admin;
    } t_access_res;

    t_access_res      pending_outcomes[$];
    logic             master_known;
    logic             admin_on;
    logic [UID_W-1:0] master_uid;
    logic             slot_used [TABLE_DEPTH];
    logic [UID_W-1:0] slot_uid  [TABLE_DEPTH];
    int unsigned      stored_keys;
    int               mismatches = 0;

    task automatic predict_card(input logic [UID_W-1:0] card, output t_access_res res);
        logic [UID_W-1:0] uid;
        logic [EV_W-1:0]  ev;
        int               hit;
        int               free_slot;
        uid       = card & UID_MASK;
        hit       = -1;
        free_slot = -1;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (slot_used[i] && slot_uid[i] == uid) hit = i;
            if (!slot_used[i]) free_slot = i;
        end
        if (!master_known) begin
            master_uid   = uid;
            master_known = 1'b1;
            ev           = EV_MASTER_SET;
        end else if (uid == master_uid) begin
            admin_on = !admin_on;
            ev       = admin_on ? EV_ENTER : EV_LEAVE;
        end else if (!admin_on) begin
            ev = (hit >= 0) ? EV_GRANTED : EV_DENIED;
        end else if (hit >= 0) begin
            slot_used[hit] = 1'b0;
            if (stored_keys > 0) stored_keys--;
            ev = EV_REMOVED;
        end else if (free_slot >= 0) begin
            slot_used[free_slot] = 1'b1;
            slot_uid[free_slot]  = uid;
            stored_keys++;
            ev = EV_ADDED;
        end else begin
            ev = EV_FULL;
        end
        res.ev    = ev;
        res.count = CNT_OUT_W'(stored_keys);
        res.admin = admin_on;
    endtask

    task automatic check_result(input logic [RES_PAD_W-1:0] beat);
        t_access_res want;
        if (pending_outcomes.size() == 0) begin
            $error("result beat %h with no card pending", beat);
            mismatches++;
        end else begin
            want = pending_outcomes.pop_front();
            if (beat[EV_W-1:0] !== want.ev) begin
                $error("event_res: expected %0d, actual %0d", want.ev, beat[EV_W-1:0]);
                mismatches++;
            end
            if (beat[EV_W +: CNT_OUT_W] !== want.count) begin
                $error("stored_count: expected %0d, actual %0d", want.count,
                       beat[EV_W +: CNT_OUT_W]);
                mismatches++;
            end
            if (beat[RES_W-1] !== want.admin) begin
                $error("admin_mode: expected %0d, actual %0d", want.admin, beat[RES_W-1]);
                mismatches++;
            end
            if (beat[RES_PAD_W-1:RES_W] !== '0) begin
                $error("padding: expected 0, actual %h", beat[RES_PAD_W-1:RES_W]);
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_access_res res;
        if (!i_rst_n) begin
            master_known = 1'b0;
            admin_on     = 1'b0;
            stored_keys  = 0;
            for (int i = 0; i < TABLE_DEPTH; i++) slot_used[i] = 1'b0;
            pending_outcomes.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) check_result(i_m_tdata);
            if (i_s_tvalid && i_s_tready) begin
                predict_card(i_s_tdata, res);
                pending_outcomes.push_back(res);
            end
        end
        o_pending <= pending_outcomes.size();
        o_errors  <= mismatches;
    end

endmodule

// ----- verif/tb_rfid_key_whitelist_controller.sv -----
// Testbench top for the key whitelist controller: clock, reset, card stimulus and verdict.
module tb_rfid_key_whitelist_controller;
    import rkwc_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int SEGMENTS   = 9;
    localparam int SEG_CARDS  = 50;
    localparam int POOL_SIZE  = 32;
    localparam int LONG_HOLD  = 200;
    localparam logic [UID_W-1:0] MASTER_UID = 32'hFFFF_FFFF;

    logic                 i_clk;
    logic                 i_rst_n  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [UID_W-1:0]     s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [RES_PAD_W-1:0] m_tdata;

    int               pending;
    int               errors;
    int               hold_reqs = 0;
    bit               calm      = 1'b0;
    logic [UID_W-1:0] card_pool [POOL_SIZE];

    rfid_key_whitelist_controller i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    rkwc_checker i_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .o_pending  (pending),
        .o_errors   (errors)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(CLK_PERIOD * 400_000);
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 0;
        if (r < 9) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [UID_W-1:0] pick_card(input int pool_n);
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return MASTER_UID;
        if (r < 85) return card_pool[$urandom_range(0, pool_n - 1)];
        return $urandom;
    endfunction

    // receiver: random stalls, long hold on request
    initial begin
        int stall;
        int hold_seen;
        stall     = 0;
        hold_seen = 0;
        forever begin
            @(negedge i_clk);
            if (hold_seen != hold_reqs) begin
                hold_seen = hold_reqs;
                stall     = LONG_HOLD;
            end else if (stall == 0 && !calm && $urandom_range(0, 3) == 0) begin
                stall = idle_len();
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                stall--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_card(input logic [UID_W-1:0] uid);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            s_tdata  <= $urandom;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= uid;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        int pool_n;
        for (int i = 0; i < POOL_SIZE; i++) card_pool[i] = $urandom;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_card(MASTER_UID);
        send_card(32'h0000_0000);
        send_card(MASTER_UID);
        send_card(32'h0000_0000);
        send_card(32'h0000_0001);
        send_card(32'h0000_0000);
        send_card(MASTER_UID);
        send_card(32'h0000_0001);
        send_card(MASTER_UID);
        for (int k = 1; k < 16; k++) send_card(32'h1 << k);
        send_card(32'h8000_0000);
        send_card(MASTER_UID);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg == 3 || seg == 7) drain_results();
            if (seg == 2 || seg == 6) hold_reqs++;
            calm   = (seg == 4);
            pool_n = $urandom_range(4, POOL_SIZE);
            for (int n = 0; n < SEG_CARDS; n++) send_card(pick_card(pool_n));
        end
        calm = 1'b0;

        drain_results();
        repeat (40) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/rkwc_pkg.sv
rtl/rkwc_ctrl.sv
rtl/rkwc_dp.sv
rtl/rfid_key_whitelist_controller.sv
verif/rkwc_checker.sv
verif/tb_rfid_key_whitelist_controller.sv
